// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants of the sliding-window median filter.
// Depends on nothing; every other file of the block refers to it by scoped names.

package swm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CHANNELS   = 4;
  localparam int WINDOW_DEF = 10;
  localparam int READY_MIN  = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_SHIFT,
    S_DONE
  } state_t;

  // Commands from the sequencer to every channel's sorting row.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } sort_ctrl_t;

endpackage

// ===== rtl/core/swm_if.sv =====
// Handshake interfaces of the median filter: the sample channel and the result channel.
// Depends on swm_pkg for the sample type.

interface swm_in_if;
  logic            valid;
  logic            ready;
  swm_pkg::sample_t sample_a;
  swm_pkg::sample_t sample_b;
  swm_pkg::sample_t sample_c;
  swm_pkg::sample_t sample_d;

  modport source (output valid, output sample_a, output sample_b, output sample_c,
                  output sample_d, input ready);
  modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                  input sample_d, output ready);
endinterface

interface swm_out_if;
  logic            valid;
  logic            ready;
  swm_pkg::sample_t median_a;
  swm_pkg::sample_t median_b;
  swm_pkg::sample_t median_c;
  swm_pkg::sample_t median_d;
  logic            ready_res;

  modport source (output valid, output median_a, output median_b, output median_c,
                  output median_d, output ready_res, input ready);
  modport sink   (input valid, input median_a, input median_b, input median_c,
                  input median_d, input ready_res, output ready);
endinterface

// ===== rtl/core/swm_window_ram.sv =====
// Window store: one row per ring slot, all channels side by side in a row.
// Synchronous write, registered read. Depends on swm_pkg.

module swm_window_ram #(
  parameter int DEPTH = swm_pkg::WINDOW_DEF,
  parameter int WIDTH = swm_pkg::SAMPLE_W * swm_pkg::CHANNELS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/swm_sorter.sv =====
// Sorting row of one channel: samples are inserted one per cycle into an ascending row.
// Shifting the row down moves the middle values to the two lowest positions. Depends on swm_pkg.

module swm_sorter #(
  parameter int DEPTH = swm_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::sort_ctrl_t ctrl,
  input  swm_pkg::sample_t    din,
  output swm_pkg::sample_t    lo,
  output swm_pkg::sample_t    hi
);

  swm_pkg::sample_t val_r   [DEPTH];
  swm_pkg::sample_t val_nxt [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic [DEPTH-1:0] gt;

  // Empty positions count as greater, so gt is zeros followed by ones.
  for (genvar k = 0; k < DEPTH; k++) begin : g_pos
    assign gt[k] = !vld_r[k] || (val_r[k] > din);

    if (k == 0) begin : g_first
      always_comb begin
        if (ctrl.insert) begin
          val_nxt[k] = gt[k] ? din : val_r[k];
        end else if (ctrl.shift) begin
          val_nxt[k] = val_r[k+1];
        end else begin
          val_nxt[k] = val_r[k];
        end
      end
      assign vld_nxt[k] = ctrl.clear ? 1'b0 : (ctrl.insert ? 1'b1 : vld_r[k]);
    end else begin : g_rest
      always_comb begin
        if (ctrl.insert) begin
          if (gt[k]) begin
            val_nxt[k] = gt[k-1] ? val_r[k-1] : din;
          end else begin
            val_nxt[k] = val_r[k];
          end
        end else if (ctrl.shift) begin
          val_nxt[k] = (k == DEPTH - 1) ? val_r[k] : val_r[(k + 1) % DEPTH];
        end else begin
          val_nxt[k] = val_r[k];
        end
      end
      assign vld_nxt[k] = ctrl.clear ? 1'b0 :
                          (ctrl.insert ? (vld_r[k] | vld_r[k-1]) : vld_r[k]);
    end

    always_ff @(posedge clk) begin
      val_r[k] <= val_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign lo = val_r[0];
  assign hi = val_r[1];

endmodule

// ===== rtl/core/sliding_window_median_filter.sv =====
// Top level of the sliding-window median filter: sequencer, ring counters and result register.
// Depends on swm_pkg, swm_if, swm_window_ram and swm_sorter.
//
//   channel  direction  payload                                   transfer when
//   in_ch    sink       sample_a..sample_d, 16 bit signed         valid && ready
//   out_ch   source     median_a..median_d, ready_res             valid && ready
//
// An item's samples are read back from the window store, one row per cycle from its single
// read port, inserted into the sorting rows and shifted down before the result is loaded.
// Reset clears the state, the ring counters, the sorting rows' valid bits and the result valid flag.
// A finished result waits in the output register while the next item is taken in;
// the sequencer holds only if that register is still full when the next result is done.

module sliding_window_median_filter #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  swm_in_if.sink         in_ch,
  swm_out_if.source      out_ch
);

  localparam int AW  = $clog2(WINDOW);
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SW  = swm_pkg::SAMPLE_W;
  localparam int NCH = swm_pkg::CHANNELS;

  swm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] shift_r, shift_nxt;
  logic          rvalid_r;

  logic          in_xfer;
  logic          rd_last;
  logic          load_out;
  logic          mem_re;
  logic [AW-1:0] slot;
  logic [SW*NCH-1:0] wdata;
  logic [SW*NCH-1:0] rdata;
  swm_pkg::sort_ctrl_t sctrl;

  swm_pkg::sample_t lo [NCH];
  swm_pkg::sample_t hi [NCH];
  swm_pkg::sample_t med [NCH];
  swm_pkg::sample_t med_r [NCH];
  logic             ready_res_r;
  logic             out_valid_r;
  logic             have3;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign rd_last = (CW'(rd_idx_r) == n_r - CW'(1));
  assign have3   = (n_r >= CW'(swm_pkg::READY_MIN));
  assign wdata   = {in_ch.sample_d, in_ch.sample_c, in_ch.sample_b, in_ch.sample_a};

  // While filling, the oldest slot stays at zero, so the new slot is the fill count.
  assign slot = (fill_r < CW'(WINDOW)) ? fill_r[AW-1:0] : oldest_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swm_pkg::S_IDLE:  if (in_ch.valid) state_nxt = swm_pkg::S_READ;
      swm_pkg::S_READ:  if (rd_last) state_nxt = swm_pkg::S_WAIT;
      swm_pkg::S_WAIT:  state_nxt = swm_pkg::S_SHIFT;
      swm_pkg::S_SHIFT: if (shift_r == '0) state_nxt = swm_pkg::S_DONE;
      swm_pkg::S_DONE:  if (load_out) state_nxt = swm_pkg::S_IDLE;
      default:          state_nxt = swm_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready  = 1'b0;
    mem_re       = 1'b0;
    sctrl        = '0;
    load_out     = 1'b0;
    sctrl.insert = rvalid_r;
    case (state_r)
      swm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        sctrl.clear = in_ch.valid;
      end
      swm_pkg::S_READ:  mem_re = 1'b1;
      swm_pkg::S_WAIT:  ;
      swm_pkg::S_SHIFT: sctrl.shift = (shift_r != '0);
      swm_pkg::S_DONE:  load_out = !out_valid_r || out_ch.ready;
      default:          ;
    endcase
  end

  // Ring counters and sequencing counters.
  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    n_nxt      = n_r;
    rd_idx_nxt = rd_idx_r;
    shift_nxt  = shift_r;
    if (in_xfer) begin
      if (fill_r < CW'(WINDOW)) begin
        fill_nxt = fill_r + CW'(1);
        n_nxt    = fill_r + CW'(1);
      end else begin
        oldest_nxt = (oldest_r == AW'(WINDOW - 1)) ? '0 : oldest_r + AW'(1);
        n_nxt      = fill_r;
      end
      rd_idx_nxt = '0;
    end
    if (mem_re) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
    // Dropping the lowest (n-1)/2 values leaves the middle pair at the bottom.
    if (state_r == swm_pkg::S_WAIT) begin
      shift_nxt = (n_r - CW'(1)) >> 1;
    end else if (sctrl.shift) begin
      shift_nxt = shift_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::S_IDLE;
      fill_r      <= '0;
      oldest_r    <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      rvalid_r <= mem_re;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    rd_idx_r <= rd_idx_nxt;
    shift_r  <= shift_nxt;
  end

  swm_window_ram #(
    .DEPTH (WINDOW),
    .WIDTH (SW * NCH)
  ) u_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (slot),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    logic signed [SW:0] sum;

    swm_sorter #(
      .DEPTH (WINDOW)
    ) u_sorter (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (sctrl),
      .din   (rdata[c*SW +: SW]),
      .lo    (lo[c]),
      .hi    (hi[c])
    );

    // Even count: floor of the mean, taken from the 17-bit sum.
    assign sum = {lo[c][SW-1], lo[c]} + {hi[c][SW-1], hi[c]};

    always_comb begin
      if (!have3) begin
        med[c] = '0;
      end else if (n_r[0]) begin
        med[c] = lo[c];
      end else begin
        med[c] = sum[SW:1];
      end
    end

    always_ff @(posedge clk) begin
      if (load_out) begin
        med_r[c] <= med[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ready_res_r <= have3;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.median_a  = med_r[0];
  assign out_ch.median_b  = med_r[1];
  assign out_ch.median_c  = med_r[2];
  assign out_ch.median_d  = med_r[3];
  assign out_ch.ready_res = ready_res_r;

endmodule

// ===== tb/swm_median_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the median filter: rebuilds each channel's sample window from the
// transfers into the block and checks every result transfer against it.
// Depends on swm_pkg and the handshake interfaces in swm_if.

module swm_median_checker (
  input  logic clk,
  input  logic rst_n,
  swm_in_if    in_mon,
  swm_out_if   out_mon,
  output int   err_count,
  output int   exp_pending
);

  localparam int WIN = swm_pkg::WINDOW_DEF;

  typedef struct packed {
    logic             rdy;
    swm_pkg::sample_t med_a;
    swm_pkg::sample_t med_b;
    swm_pkg::sample_t med_c;
    swm_pkg::sample_t med_d;
  } median_set_t;

  swm_pkg::sample_t history [swm_pkg::CHANNELS][WIN];
  int unsigned held   = 0;
  int unsigned oldest = 0;
  median_set_t median_q [$];
  median_set_t next_set;
  median_set_t seen_set;
  median_set_t due_set;
  int          failures = 0;

  function automatic swm_pkg::sample_t window_median(input int ch);
    swm_pkg::sample_t sorted [WIN];
    swm_pkg::sample_t v;
    int               j;
    int               pair_sum;
    for (int i = 0; i < int'(held); i++) begin
      v = history[ch][i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (held % 2 == 1)
      return sorted[held/2];
    // Sum at full width, then an arithmetic shift rounds toward minus infinity.
    pair_sum = int'(sorted[held/2 - 1]) + int'(sorted[held/2]);
    return swm_pkg::sample_t'(pair_sum >>> 1);
  endfunction

  function automatic median_set_t accept_item(input swm_pkg::sample_t a,
                                              input swm_pkg::sample_t b,
                                              input swm_pkg::sample_t c,
                                              input swm_pkg::sample_t d);
    median_set_t res;
    int unsigned slot;
    if (held < WIN) begin
      slot = (oldest + held) % WIN;
      held++;
    end else begin
      slot = oldest;
      oldest = (oldest + 1) % WIN;
    end
    history[0][slot] = a;
    history[1][slot] = b;
    history[2][slot] = c;
    history[3][slot] = d;
    res = '0;
    if (held >= swm_pkg::READY_MIN) begin
      res.rdy   = 1'b1;
      res.med_a = window_median(0);
      res.med_b = window_median(1);
      res.med_c = window_median(2);
      res.med_d = window_median(3);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input median_set_t want,
                                 input median_set_t got);
    failures++;
    if (failures <= 10)
      $display("%0t ns: %s: expected ready=%0b medians %0d %0d %0d %0d, %s%0b %s %0d %0d %0d %0d",
               $time, what, want.rdy, want.med_a, want.med_b, want.med_c, want.med_d,
               "got ready=", got.rdy, "medians",
               got.med_a, got.med_b, got.med_c, got.med_d);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      oldest = 0;
      median_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        next_set = accept_item(in_mon.sample_a, in_mon.sample_b,
                               in_mon.sample_c, in_mon.sample_d);
        median_q = {median_q, next_set};
      end
      if (out_mon.valid && out_mon.ready) begin
        seen_set.rdy   = out_mon.ready_res;
        seen_set.med_a = out_mon.median_a;
        seen_set.med_b = out_mon.median_b;
        seen_set.med_c = out_mon.median_c;
        seen_set.med_d = out_mon.median_d;
        if (median_q.size() == 0) begin
          report_mismatch("result transfer with no item outstanding", '0, seen_set);
        end else begin
          due_set = median_q.pop_front();
          if (seen_set.rdy !== due_set.rdy || seen_set.med_a !== due_set.med_a ||
              seen_set.med_b !== due_set.med_b || seen_set.med_c !== due_set.med_c ||
              seen_set.med_d !== due_set.med_d)
            report_mismatch("median mismatch", due_set, seen_set);
        end
      end
    end
    err_count   <= failures;
    exp_pending <= median_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the median filter testbench: clock, reset, sample stimulus and result back-pressure.
// Depends on swm_pkg, swm_if, the filter RTL and swm_median_checker.

module tb;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  int               err_count;
  int               exp_pending;
  int               src_idle_pct  = 0;
  int               sink_idle_pct = 0;
  bit               hold_pending  = 1'b0;
  swm_pkg::sample_t centre [swm_pkg::CHANNELS];
  swm_pkg::sample_t corner [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                   16'h0001, 16'h5555, 16'hAAAA, 16'hFFFE};

  sliding_window_median_filter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  swm_median_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .err_count   (err_count),
    .exp_pending (exp_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Half full-range values, some clustered near a drifting level so that ties and
  // near-ties show up inside a window, and some corner values.
  function automatic swm_pkg::sample_t pick_sample(input swm_pkg::sample_t level);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5)
      return swm_pkg::sample_t'($urandom);
    if (mode < 8)
      return level + swm_pkg::sample_t'($urandom_range(0, 16)) - swm_pkg::sample_t'(8);
    return corner[$urandom_range(0, 7)];
  endfunction

  // Leaves valid high between back-to-back items; it only drops when a gap is taken.
  task automatic send_sample(input swm_pkg::sample_t a, input swm_pkg::sample_t b,
                             input swm_pkg::sample_t c, input swm_pkg::sample_t d);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    in_ch.sample_c <= c;
    in_ch.sample_d <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0)
        foreach (centre[ch]) centre[ch] = swm_pkg::sample_t'($urandom);
      send_sample(pick_sample(centre[0]), pick_sample(centre[1]),
                  pick_sample(centre[2]), pick_sample(centre[3]));
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample_a <= '0;
    in_ch.sample_b <= '0;
    in_ch.sample_c <= '0;
    in_ch.sample_d <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 27;
    sink_idle_pct = 81;
    // Corner values: the first two items leave the window too short to report, the
    // next ones alternate odd and even counts, and the last ones wrap the full ring.
    for (int i = 0; i < 24; i++)
      send_sample(corner[i % 8], corner[(i + 3) % 8], corner[(i * 5 + 1) % 8],
                  corner[7 - (i % 8)]);
    send_random(260);

    src_idle_pct  = 81;
    sink_idle_pct = 27;
    send_random(260);

    // No idling; the long hold-off on the result side backs the block up into its input.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_pending  = 1'b1;
    send_random(280);
    in_ch.valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && exp_pending == 0) begin
      $display("sliding_window_median_filter test passed");
    end else begin
      $display("sliding_window_median_filter test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sliding_window_median_filter test failed");
    $finish;
  end

endmodule
